FILE: rtl/wfts_pkg.sv
// Package for the weighted fair tick scheduler: word types, constants, level factor.
// No dependencies.
package wfts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int VRT_W = 40;
  localparam int RUN_W = 16;
  localparam int AGE_W = 24;
  localparam int ID_W  = 16;
  localparam int LVL_W = 4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  slot;
    logic [15:0] task_ident;
    logic [3:0]  task_level;
    logic [15:0] burst_len;
  } in_word_t;

  typedef struct packed {
    logic        ran;
    logic [15:0] ran_ident;
    logic        switched;
    logic        all_done;
  } out_word_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // write slot from input word
    logic clr;      // clear scan accumulators
    logic grow;     // grow runtime of scan slot
    logic scan_min; // runtime minimum pass
    logic scan_wait;// wait maximum pass
    logic scan_pick;// level pick pass
    logic commit;   // update chosen and others
  } dp_cmd_t;

  // level factor: 1 up to level 9, 2 at level 10, 3 at level 11, 6 from level 12 up
  function automatic logic [2:0] level_factor(input logic [3:0] lvl);
    logic [2:0] f;
    begin
      if (lvl <= 4'd9) f = 3'd1;
      else if (lvl == 4'd10) f = 3'd2;
      else if (lvl == 4'd11) f = 3'd3;
      else f = 3'd6;
      return f;
    end
  endfunction

endpackage

FILE: rtl/weighted_fair_tick_scheduler_unit.sv
// Top level of the weighted fair tick scheduler.
// Depends on wfts_pkg, wfts_ctrl and wfts_dp.
//
// Usage:
//   Raise start with a word on in_word while busy is low; the word is taken at
//   that edge. A load word writes one slot and clears its counters; a tick word
//   grows runtimes, picks the unfinished task with the least runtime (then the
//   longest waiter, then the lowest level, then the lowest slot) and gives it one
//   slice.
//   Each word gives one result on out_word, marked by out_valid for one cycle.
//   A load gives its result the cycle after acceptance and busy stays low,
//   so loads can follow each cycle. A tick makes four passes over the table,
//   one slot a cycle each (runtime growth, runtime minimum, wait maximum,
//   level pick), then a commit, from which the result is registered.
//   The receiver cannot stall; results must be taken when strobed.
//   Synchronous reset clears the loaded flags, the last chosen slot and the
//   controller; slot contents are only read once loaded.
module weighted_fair_tick_scheduler_unit import wfts_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output out_word_t out_word,
  output logic      out_valid
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  dp_cmd_t          cmd;
  logic [IDX_W-1:0] idx;
  logic             done;

  wfts_ctrl #(.TASK_SLOTS(TASK_SLOTS), .IDX_W(IDX_W)) u_ctrl (
    .clk, .rst_n, .start, .action(in_word.action), .busy, .cmd, .idx, .done
  );

  wfts_dp #(.TASK_SLOTS(TASK_SLOTS), .IDX_W(IDX_W)) u_dp (
    .clk, .rst_n, .in_word, .cmd, .idx, .done, .out_word, .out_valid
  );

endmodule

FILE: rtl/wfts_ctrl.sv
// Controller for the scheduler: sequences grow and scan passes over the slots.
// Depends on wfts_pkg.
module wfts_ctrl import wfts_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             action,
  output logic             busy,
  output dp_cmd_t          cmd,
  output logic [IDX_W-1:0] idx,
  output logic             done
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GROW = 3'd1;
  localparam logic [2:0] S_MIN  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_COMM = 3'd5;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TASK_SLOTS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  assign busy = (state_r != S_IDLE);
  assign idx  = idx_r;

  // state sequencing, one slot per cycle in each pass
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_LOAD) begin
            cmd.load = 1'b1;
            done     = 1'b1;
          end else begin
            cmd.clr   = 1'b1;
            state_nxt = S_GROW;
            idx_nxt   = '0;
          end
        end
      end
      S_GROW: begin
        cmd.grow = 1'b1;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_MIN;
          idx_nxt   = '0;
        end
      end
      S_MIN: begin
        cmd.scan_min = 1'b1;
        idx_nxt      = idx_r + 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_WAIT;
          idx_nxt   = '0;
        end
      end
      S_WAIT: begin
        cmd.scan_wait = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_PICK;
          idx_nxt   = '0;
        end
      end
      S_PICK: begin
        cmd.scan_pick = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_COMM;
          idx_nxt   = '0;
        end
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        done       = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: rtl/wfts_dp.sv
// Datapath for the scheduler: slot table, counters, scan accumulators, result word.
// Depends on wfts_pkg.
module wfts_dp import wfts_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_word_t         in_word,
  input  dp_cmd_t          cmd,
  input  logic [IDX_W-1:0] idx,
  input  logic             done,
  output out_word_t        out_word,
  output logic             out_valid
);

  localparam logic [VRT_W-1:0] VRT_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // slot table
  logic [TASK_SLOTS-1:0] loaded_r;
  logic [ID_W-1:0]       ident_r [TASK_SLOTS];
  logic [LVL_W-1:0]      level_r [TASK_SLOTS];
  logic [15:0]           work_r  [TASK_SLOTS];
  logic [VRT_W-1:0]      vrt_r   [TASK_SLOTS];
  logic [RUN_W-1:0]      run_r   [TASK_SLOTS];
  logic [AGE_W-1:0]      age_r   [TASK_SLOTS];
  logic [IDX_W-1:0]      last_r;

  // scan accumulators
  logic             any_r;
  logic [VRT_W-1:0] vmin_r;
  logic [AGE_W-1:0] wmax_r;
  logic             found_r;
  logic [IDX_W-1:0] pick_r;
  logic [LVL_W-1:0] plvl_r;

  out_word_t out_r;
  logic      valid_r;

  logic       in_range;
  logic       live;
  logic [18:0] add;
  logic [VRT_W:0] grown;
  logic [TASK_SLOTS-1:0] busy_vec;
  logic       all_done;
  logic       do_load;

  assign in_range = (32'(in_word.slot) < TASK_SLOTS);
  assign do_load  = cmd.load && in_range;
  assign live     = loaded_r[idx] && (work_r[idx] != '0);
  assign add      = 19'(level_factor(level_r[idx])) * 19'(run_r[idx]);
  assign grown    = {1'b0, vrt_r[idx]} + (VRT_W+1)'(add);

  // all done, taken from the table after this item's update
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      busy_vec[i] = loaded_r[i] && (work_r[i] != '0);
      if (do_load && (IDX_W'(in_word.slot) == IDX_W'(i)))
        busy_vec[i] = (in_word.burst_len != '0);
      if (cmd.commit && any_r && (pick_r == IDX_W'(i)))
        busy_vec[i] = (work_r[i] != 16'd1);
    end
    all_done = (busy_vec == '0);
  end

  // table writes
  always_ff @(posedge clk) begin
    if (do_load) begin
      ident_r[IDX_W'(in_word.slot)] <= in_word.task_ident;
      level_r[IDX_W'(in_word.slot)] <= in_word.task_level;
      work_r[IDX_W'(in_word.slot)]  <= in_word.burst_len;
      vrt_r[IDX_W'(in_word.slot)]   <= '0;
      run_r[IDX_W'(in_word.slot)]   <= '0;
      age_r[IDX_W'(in_word.slot)]   <= '0;
    end
    if (cmd.grow && loaded_r[idx])
      vrt_r[idx] <= grown[VRT_W] ? VRT_MAX : grown[VRT_W-1:0];
    if (cmd.commit && any_r) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (pick_r == IDX_W'(i)) begin
          work_r[i] <= work_r[i] - 16'd1;
          if (run_r[i] != RUN_MAX) run_r[i] <= run_r[i] + 1'b1;
        end else if (loaded_r[i] && age_r[i] != AGE_MAX) begin
          age_r[i] <= age_r[i] + 1'b1;
        end
      end
    end
  end

  // scan passes
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      any_r   <= 1'b0;
      found_r <= 1'b0;
      wmax_r  <= '0;
    end
    if (cmd.scan_min && live) begin
      if (!any_r || vrt_r[idx] < vmin_r) vmin_r <= vrt_r[idx];
      any_r <= 1'b1;
    end
    if (cmd.scan_wait && live && vrt_r[idx] == vmin_r && age_r[idx] > wmax_r)
      wmax_r <= age_r[idx];
    if (cmd.scan_pick && live && vrt_r[idx] == vmin_r && age_r[idx] == wmax_r) begin
      if (!found_r || level_r[idx] < plvl_r) begin
        pick_r <= idx;
        plvl_r <= level_r[idx];
      end
      found_r <= 1'b1;
    end
  end

  // control state: loaded flags, last chosen, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      last_r   <= '0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= done;
      if (do_load) loaded_r[IDX_W'(in_word.slot)] <= 1'b1;
      if (cmd.commit && any_r) last_r <= pick_r;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (done) begin
      out_r.ran       <= cmd.commit && any_r;
      out_r.ran_ident <= (cmd.commit && any_r) ? ident_r[pick_r] : '0;
      out_r.switched  <= cmd.commit && any_r && (pick_r != last_r);
      out_r.all_done  <= all_done;
    end
  end

  assign out_word  = out_r;
  assign out_valid = valid_r;

endmodule

FILE: test/testbench.sv
// Testbench for weighted_fair_tick_scheduler_unit: load and tick words, checked
// against a built-in scheduler predictor. Depends on wfts_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import wfts_pkg::*;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 2000;
  localparam logic [39:0] VRT_SAT = 40'hFF_FFFF_FFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  out_word_t out_word;
  logic      out_valid;

  // predictor state
  logic        tbl_loaded [NSLOT];
  logic [15:0] tbl_ident [NSLOT];
  logic [3:0]  tbl_level [NSLOT];
  logic [15:0] tbl_work [NSLOT];
  logic [39:0] tbl_vrt [NSLOT];
  logic [15:0] tbl_runs [NSLOT];
  logic [23:0] tbl_age [NSLOT];
  logic [3:0]  prev_pick;

  // expected words in order, small ring with running write and read counts
  out_word_t exp_ring [8];
  int  exp_wr = 0;
  int  exp_rd = 0;
  int  n_fail = 0;
  int  idle_pct = 31;
  int  quiet_cycles = 0;

  weighted_fair_tick_scheduler_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_word(out_word), .out_valid(out_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [39:0] growth_factor(input logic [3:0] lvl);
    if (lvl <= 4'd9) return 40'd1;
    else if (lvl == 4'd10) return 40'd2;
    else if (lvl == 4'd11) return 40'd3;
    return 40'd6;
  endfunction

  function automatic logic no_work_left();
    for (int i = 0; i < NSLOT; i++)
      if (tbl_loaded[i] && tbl_work[i] != 0) return 1'b0;
    return 1'b1;
  endfunction

  // next scheduler decision for one word
  function automatic out_word_t schedule_word(input in_word_t w);
    out_word_t r;
    logic [40:0] sum;
    logic any, found;
    logic [39:0] vmin;
    logic [23:0] wmax;
    int pick;
    r = '0; any = 1'b0; found = 1'b0; vmin = '0; wmax = '0; pick = 0;
    if (w.action == ACT_LOAD) begin
      tbl_loaded[w.slot] = 1'b1;
      tbl_ident[w.slot] = w.task_ident;
      tbl_level[w.slot] = w.task_level;
      tbl_work[w.slot] = w.burst_len;
      tbl_vrt[w.slot] = '0;
      tbl_runs[w.slot] = '0;
      tbl_age[w.slot] = '0;
    end else begin
      for (int i = 0; i < NSLOT; i++)
        if (tbl_loaded[i]) begin
          sum = {1'b0, tbl_vrt[i]} + growth_factor(tbl_level[i]) * tbl_runs[i];
          tbl_vrt[i] = (sum > {1'b0, VRT_SAT}) ? VRT_SAT : sum[39:0];
        end
      for (int i = 0; i < NSLOT; i++)
        if (tbl_loaded[i] && tbl_work[i] != 0) begin
          if (!any || tbl_vrt[i] < vmin) vmin = tbl_vrt[i];
          any = 1'b1;
        end
      if (any) begin
        for (int i = 0; i < NSLOT; i++)
          if (tbl_loaded[i] && tbl_work[i] != 0 && tbl_vrt[i] == vmin &&
              tbl_age[i] > wmax) wmax = tbl_age[i];
        for (int i = 0; i < NSLOT; i++)
          if (tbl_loaded[i] && tbl_work[i] != 0 && tbl_vrt[i] == vmin &&
              tbl_age[i] == wmax) begin
            if (!found || tbl_level[i] < tbl_level[pick]) pick = i;
            found = 1'b1;
          end
        r.ran = 1'b1;
        r.ran_ident = tbl_ident[pick];
        r.switched = (pick[3:0] != prev_pick);
        prev_pick = pick[3:0];
        if (tbl_runs[pick] != 16'hFFFF) tbl_runs[pick]++;
        tbl_work[pick]--;
        for (int i = 0; i < NSLOT; i++)
          if (tbl_loaded[i] && i != pick && tbl_age[i] != 24'hFF_FFFF) tbl_age[i]++;
      end
    end
    r.all_done = no_work_left();
    return r;
  endfunction

  // send one word, idling at random first; start stays high into the next word
  task automatic send_word(input in_word_t w);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < idle_pct) gaps++;
    if (gaps > 0) begin
      start <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_ring[exp_wr[2:0]] = schedule_word(w);
    exp_wr++;
    @(negedge clk);
  endtask

  task automatic load_slot(input logic [3:0] s, input logic [15:0] id,
                           input logic [3:0] lvl, input logic [15:0] burst);
    in_word_t w;
    w.action = ACT_LOAD; w.slot = s; w.task_ident = id;
    w.task_level = lvl; w.burst_len = burst;
    send_word(w);
  endtask

  task automatic tick_once();
    in_word_t w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.action = ACT_TICK;
    send_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (exp_wr == exp_rd) begin
        $error("result with none expected");
        n_fail++;
      end else begin
        automatic out_word_t e = exp_ring[exp_rd[2:0]];
        exp_rd++;
        if (out_word.ran !== e.ran) begin
          $error("ran exp %0d got %0d", e.ran, out_word.ran); n_fail++;
        end
        if (out_word.ran_ident !== e.ran_ident) begin
          $error("ran_ident exp %0h got %0h", e.ran_ident, out_word.ran_ident); n_fail++;
        end
        if (out_word.switched !== e.switched) begin
          $error("switched exp %0d got %0d", e.switched, out_word.switched); n_fail++;
        end
        if (out_word.all_done !== e.all_done) begin
          $error("all_done exp %0d got %0d", e.all_done, out_word.all_done); n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with nothing accepted and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // empty table, idle ticks, extremes of fields
  task automatic test_directed();
    tick_once();
    load_slot(4'd0, 16'hFFFF, 4'd7, 16'd2);
    load_slot(4'd15, 16'h0000, 4'd12, 16'hFFFF);
    load_slot(4'd3, 16'h1234, 4'd0, 16'd1);
    load_slot(4'd4, 16'hA5A5, 4'd15, 16'd3);
    load_slot(4'd5, 16'h5A5A, 4'd10, 16'd0);
    repeat (6) tick_once();
    load_slot(4'd15, 16'hBEEF, 4'd11, 16'd1);  // reload clears counters
    repeat (4) tick_once();
    load_slot(4'd15, 16'h0001, 4'd9, 16'd0);
    repeat (3) tick_once();                    // idle ticks once all finish
  endtask

  // equal-level ties: pick falls to the longest waiter, then the lowest slot
  task automatic test_ties();
    for (int i = 0; i < 4; i++) load_slot(i[3:0] + 4'd6, 16'(256 + i), 4'd8, 16'd3);
    repeat (14) tick_once();
  endtask

  // random task sets, each run to near completion
  task automatic test_random(input int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      if (sent > words / 2 && sent < words / 2 + 60) idle_pct = 0;
      else idle_pct = 31;
      if ($urandom_range(99) < 35)
        load_slot(4'($urandom_range(15)), 16'($urandom),
                  4'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 7)),
                  16'($urandom_range(6)));
      else tick_once();
      if ($urandom_range(99) == 0)
        load_slot(4'($urandom_range(15)), 16'($urandom), 4'($urandom_range(15)),
                  16'($urandom));
      sent++;
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_loaded[i] = 1'b0; tbl_ident[i] = '0; tbl_level[i] = '0; tbl_work[i] = '0;
      tbl_vrt[i] = '0; tbl_runs[i] = '0; tbl_age[i] = '0;
    end
    prev_pick = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_ties();
    drain();              // sender holds until every result is in
    test_random(420);
    drain();
    if (n_fail == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
